// File: rtl/input_capture_frequency_meter_defines.svh
// assertion macros shared by the rtl files
`ifndef INPUT_CAPTURE_FREQUENCY_METER_DEFINES_SVH
`define INPUT_CAPTURE_FREQUENCY_METER_DEFINES_SVH

// plain property, checked on every edge out of reset
`define ICFM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define ICFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/icfm_pkg.sv
package icfm_pkg;

	localparam int WINDOW_LEN = 10;

	localparam int NUM_W    = 27;
	localparam int LOSS_W   = 8;
	localparam int CNT_W    = 16;
	localparam int MEAS_W   = 17;
	localparam int OVF_W    = 6;
	localparam int PERIOD_W = 22;
	localparam int FREQ_W   = 32;
	localparam int FRAC_W   = 16;

	localparam int SUM_W  = PERIOD_W + $clog2(WINDOW_LEN);
	localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int FILL_W = $clog2(WINDOW_LEN + 1);

	localparam int DVD_W     = NUM_W + FRAC_W;
	localparam int DIV_STEPS = DVD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam int CFG_W     = NUM_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_NUMERATOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_LIMIT      = 1'd1;

	localparam logic [NUM_W-1:0]  NUM_RESET  = NUM_W'(1000000);
	localparam logic [LOSS_W-1:0] LOSS_RESET = LOSS_W'(20);

	localparam logic [OVF_W-1:0] OVF_LIMIT = '1;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	localparam logic MODE_EVENT = 1'b0;
	localparam logic MODE_POLL  = 1'b1;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic div_finish;
		logic load_out;
	} icfm_cmd_t;

	typedef struct packed {
		logic need_div;
	} icfm_stat_t;

endpackage

// File: rtl/icfm_in_if.sv
interface icfm_in_if import icfm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic             has_overflow;
	logic             has_capture;
	logic [CNT_W-1:0] capture_count;

	modport source (output valid, mode, has_overflow, has_capture, capture_count, input ready);
	modport sink (input valid, mode, has_overflow, has_capture, capture_count, output ready);
endinterface

// File: rtl/icfm_out_if.sv
interface icfm_out_if import icfm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FREQ_W-1:0]   freq_q16;
	logic [PERIOD_W-1:0] period_ticks;
	logic                new_period;
	logic                zero_sum_error;
	logic                signal_lost;

	modport source (output valid, freq_q16, period_ticks, new_period, zero_sum_error,
		signal_lost, input ready);
	modport sink (input valid, freq_q16, period_ticks, new_period, zero_sum_error,
		signal_lost, output ready);
endinterface

// File: rtl/icfm_ctrl.sv
`include "input_capture_frequency_meter_defines.svh"

module icfm_ctrl import icfm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  icfm_stat_t stat,
	output icfm_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              slot_free;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign slot_free    = !out_valid_q || result_ready;

	always_comb begin
		cmd            = '0;
		cmd.accept     = item_valid && (state_q == ST_IDLE);
		cmd.div_step   = (state_q == ST_DIV);
		cmd.div_finish = (state_q == ST_FIN);
		cmd.load_out   = (state_q == ST_PUSH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						step_q  <= '0;
						state_q <= stat.need_div ? ST_DIV : ST_PUSH;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ICFM_ASSERT_NEXT(a_div_entry, cmd.accept && stat.need_div, state_q == ST_DIV,
		"division not started after accepting a filled-window poll")
	`ICFM_ASSERT_NEXT(a_div_length, state_q == ST_DIV && step_q == LAST_STEP, state_q == ST_FIN,
		"division did not end after its last step")
	`ICFM_ASSERT_NEXT(a_push_hold, state_q == ST_PUSH && !slot_free,
		state_q == ST_PUSH && out_valid_q, "pending result dropped while output stalled")

endmodule

// File: rtl/icfm_dp.sv
`include "input_capture_frequency_meter_defines.svh"

module icfm_dp import icfm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 mode,
	input  logic                 has_overflow,
	input  logic                 has_capture,
	input  logic [CNT_W-1:0]     capture_count,
	input  icfm_cmd_t            cmd,
	output icfm_stat_t           stat,
	output logic [FREQ_W-1:0]    freq_q16,
	output logic [PERIOD_W-1:0]  period_ticks,
	output logic                 new_period,
	output logic                 zero_sum_error,
	output logic                 signal_lost
);

	// configuration
	logic [NUM_W-1:0]  num_q;
	logic [LOSS_W-1:0] loss_q;

	// capture machine
	logic              done_q;
	logic              armed_q;
	logic [OVF_W-1:0]  ovf_q;
	logic [CNT_W-1:0]  first_q;
	logic [MEAS_W-1:0] meas_q;

	// window
	logic [PERIOD_W-1:0] ring_q [WINDOW_LEN];
	logic [IDX_W-1:0]    widx_q;
	logic [FILL_W-1:0]   fill_q;
	logic [SUM_W-1:0]    sum_q;

	logic [FREQ_W-1:0] freq_hold_q;
	logic [LOSS_W-1:0] empty_q;

	// pending result
	logic [PERIOD_W-1:0] res_period_q;
	logic                res_fresh_q;
	logic                res_zsum_q;
	logic                res_lost_q;

	// divider
	logic [SUM_W-1:0] rem_q;
	logic [DVD_W-1:0] dvd_q;

	// output register
	logic [FREQ_W-1:0]   out_freq_q;
	logic [PERIOD_W-1:0] out_period_q;
	logic                out_fresh_q;
	logic                out_zsum_q;
	logic                out_lost_q;

	// next-state of the capture machine for a timer event
	logic              ev_done;
	logic              ev_armed;
	logic [OVF_W-1:0]  ev_ovf;
	logic [CNT_W-1:0]  ev_first;
	logic [MEAS_W-1:0] ev_meas;

	// poll values
	logic                poll_take;
	logic [PERIOD_W-1:0] period;
	logic [IDX_W-1:0]    widx_next;
	logic [FILL_W-1:0]   fill_next;
	logic [SUM_W-1:0]    sum_next;
	logic [SUM_W-1:0]    old_entry;
	logic [LOSS_W:0]     empty_next;
	logic                lost;

	// divider step
	logic [SUM_W:0] shifted;
	logic [SUM_W:0] diff;
	logic           ge;

	always_comb begin
		ev_done  = done_q;
		ev_armed = armed_q;
		ev_ovf   = ovf_q;
		ev_first = first_q;
		ev_meas  = meas_q;
		if (!done_q) begin
			if (has_overflow && armed_q) begin
				if (ovf_q == OVF_LIMIT) begin
					ev_done  = 1'b1;
					ev_armed = 1'b0;
					ev_ovf   = '0;
					ev_meas  = '0;
				end else begin
					ev_ovf = ovf_q + 1'b1;
				end
			end
			if (has_capture) begin
				if (ev_armed) begin
					if (capture_count > first_q && ev_ovf == '0) begin
						ev_meas = MEAS_W'(capture_count) - MEAS_W'(first_q);
					end else begin
						ev_meas = MEAS_W'(CNT_MAX - first_q) + MEAS_W'(capture_count);
					end
					ev_done = 1'b1;
				end else begin
					ev_first = capture_count;
					ev_meas  = '0;
					ev_done  = 1'b0;
					ev_armed = 1'b1;
					ev_ovf   = '0;
				end
			end
		end
	end

	always_comb begin
		poll_take = (mode == MODE_POLL) && done_q;
		if (ovf_q <= OVF_W'(1)) begin
			period = PERIOD_W'(meas_q);
		end else begin
			period = PERIOD_W'({ovf_q - 1'b1, {FRAC_W{1'b0}}}) + PERIOD_W'(meas_q);
		end
		widx_next = (widx_q == IDX_W'(WINDOW_LEN - 1)) ? '0 : widx_q + 1'b1;
		fill_next = (fill_q < FILL_W'(WINDOW_LEN)) ? fill_q + 1'b1 : fill_q;
		// slot being overwritten counts only once the window has filled
		old_entry = (fill_q == FILL_W'(WINDOW_LEN)) ? SUM_W'(ring_q[widx_next]) : '0;
		sum_next  = sum_q - old_entry + SUM_W'(period);
		empty_next = {1'b0, empty_q} + 1'b1;
		lost       = empty_next > {1'b0, loss_q};
		stat.need_div = poll_take && (fill_next == FILL_W'(WINDOW_LEN)) && (sum_next != '0);
	end

	always_comb begin
		shifted = {rem_q, dvd_q[DVD_W-1]};
		diff    = shifted - {1'b0, sum_q};
		ge      = shifted >= {1'b0, sum_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q       <= NUM_RESET;
			loss_q      <= LOSS_RESET;
			done_q      <= 1'b0;
			armed_q     <= 1'b0;
			ovf_q       <= '0;
			meas_q      <= '0;
			widx_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			freq_hold_q <= '0;
			empty_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_CLOCK_NUMERATOR: num_q <= cfg_wdata[NUM_W-1:0];
					REG_LOSS_LIMIT:      loss_q <= cfg_wdata[LOSS_W-1:0];
					default: ;
				endcase
			end

			if (cmd.accept) begin
				if (mode == MODE_EVENT) begin
					done_q  <= ev_done;
					armed_q <= ev_armed;
					ovf_q   <= ev_ovf;
					meas_q  <= ev_meas;
				end else if (poll_take) begin
					widx_q  <= widx_next;
					fill_q  <= fill_next;
					sum_q   <= sum_next;
					done_q  <= 1'b0;
					armed_q <= 1'b0;
					ovf_q   <= '0;
					empty_q <= '0;
					if (fill_next == FILL_W'(WINDOW_LEN) && sum_next == '0) begin
						freq_hold_q <= '0;
					end
				end else if (lost) begin
					freq_hold_q <= '0;
					empty_q     <= '0;
				end else begin
					empty_q <= empty_next[LOSS_W-1:0];
				end
			end

			if (cmd.div_finish) begin
				freq_hold_q <= (dvd_q[DVD_W-1:FREQ_W] != '0) ? '1 : dvd_q[FREQ_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (mode == MODE_EVENT) begin
				first_q <= ev_first;
			end else if (poll_take) begin
				ring_q[widx_next] <= period;
			end
			res_period_q <= poll_take ? period : '0;
			res_fresh_q  <= poll_take;
			res_zsum_q   <= poll_take && (fill_next == FILL_W'(WINDOW_LEN)) && (sum_next == '0);
			res_lost_q   <= (mode == MODE_POLL) && !done_q && lost;
			rem_q        <= '0;
			dvd_q        <= {num_q, {FRAC_W{1'b0}}};
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
		if (cmd.load_out) begin
			out_freq_q   <= freq_hold_q;
			out_period_q <= res_period_q;
			out_fresh_q  <= res_fresh_q;
			out_zsum_q   <= res_zsum_q;
			out_lost_q   <= res_lost_q;
		end
	end

	assign freq_q16       = out_freq_q;
	assign period_ticks   = out_period_q;
	assign new_period     = out_fresh_q;
	assign zero_sum_error = out_zsum_q;
	assign signal_lost    = out_lost_q;

	`ICFM_ASSERT(a_fill_range, fill_q <= FILL_W'(WINDOW_LEN), "window fill past its length")
	`ICFM_ASSERT(a_widx_range, widx_q <= IDX_W'(WINDOW_LEN - 1), "ring index out of range")
	`ICFM_ASSERT(a_rem_bound, !cmd.div_step || rem_q < sum_q,
		"divider remainder not below the window sum")

endmodule

// File: rtl/input_capture_frequency_meter.sv
// input capture period and frequency meter
//
// item channel (sink): mode 0 is a timer event carrying wrap and capture
// flags plus the latched 16-bit count; mode 1 is a poll that takes a
// finished period into a ring of WINDOW_LEN entries
// result channel (source): exactly one result transaction per item
// config port: cfg_wr_en/cfg_index/cfg_wdata, index 0 clock_numerator,
// index 1 loss_limit, write only while the block is idle
// an event, an empty poll, a poll before the window is full or one whose
// window sum is zero goes from idle straight to the push state; a poll
// with a full window and a nonzero sum first runs the shift-subtract
// divider, one quotient bit per cycle over 43 bits, then a finish state,
// and only then the push state; the divider sets the rate
// one item is in flight at a time; the next item is accepted once the
// previous result sits in the output register, even if not yet taken
// a stalled receiver holds the output register and the pending result,
// which in turn holds off further items
// reset clears the capture machine, window count, held frequency and
// empty-poll count; ring contents are only read after the window filled
module input_capture_frequency_meter import icfm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	icfm_in_if.sink              item,
	icfm_out_if.source           result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	icfm_cmd_t  cmd;
	icfm_stat_t stat;

	// sequencer: accept, divider steps, result push
	icfm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// capture machine, period ring, running sum, divider and output register
	icfm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mode           (item.mode),
		.has_overflow   (item.has_overflow),
		.has_capture    (item.has_capture),
		.capture_count  (item.capture_count),
		.cmd            (cmd),
		.stat           (stat),
		.freq_q16       (result.freq_q16),
		.period_ticks   (result.period_ticks),
		.new_period     (result.new_period),
		.zero_sum_error (result.zero_sum_error),
		.signal_lost    (result.signal_lost)
	);

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import icfm_pkg::*;

	// one accepted item and one result, at the widths of the block
	typedef struct packed {
		logic             mode;
		logic             has_overflow;
		logic             has_capture;
		logic [CNT_W-1:0] capture_count;
	} meter_item_t;

	typedef struct packed {
		logic [FREQ_W-1:0]   freq_q16;
		logic [PERIOD_W-1:0] period_ticks;
		logic                new_period;
		logic                zero_sum_error;
		logic                signal_lost;
	} meter_reading_t;

	// tracks the meter state, predicts one reading per item and checks the
	// readings in order
	class meter_tracker;
		logic [NUM_W-1:0]    numerator;
		logic [LOSS_W-1:0]   loss_limit;
		logic                done;
		logic                armed;
		logic [OVF_W-1:0]    wraps;
		logic [CNT_W-1:0]    first_cnt;
		logic [MEAS_W-1:0]   ticks;
		logic [PERIOD_W-1:0] ring [WINDOW_LEN];
		int                  wr_idx;
		int                  fill;
		logic [FREQ_W-1:0]   freq;
		logic [LOSS_W-1:0]   misses;
		meter_reading_t      readings_due[$];
		int                  errors;

		function new();
			numerator = NUM_RESET;
			loss_limit = LOSS_RESET;
			done = 1'b0;
			armed = 1'b0;
			wraps = '0;
			first_cnt = '0;
			ticks = '0;
			foreach (ring[i]) ring[i] = '0;
			wr_idx = 0;
			fill = 0;
			freq = '0;
			misses = '0;
			errors = 0;
		endfunction

		function void set_registers(logic [NUM_W-1:0] num, logic [LOSS_W-1:0] limit);
			numerator = num;
			loss_limit = limit;
		endfunction

		// capture machine: wrap handled first, then the edge
		function void capture_step(logic wrap, logic cap, logic [CNT_W-1:0] cnt);
			if (done)
				return;
			if (wrap && armed) begin
				if (wraps == OVF_LIMIT) begin
					done = 1'b1;
					armed = 1'b0;
					wraps = '0;
					ticks = '0;
				end else begin
					wraps = wraps + 1'b1;
				end
			end
			if (cap) begin
				if (armed) begin
					if (cnt > first_cnt && wraps == '0)
						ticks = MEAS_W'(cnt) - MEAS_W'(first_cnt);
					else
						ticks = MEAS_W'(CNT_MAX - first_cnt) + MEAS_W'(cnt);
					done = 1'b1;
				end else begin
					first_cnt = cnt;
					ticks = '0;
					done = 1'b0;
					armed = 1'b1;
					wraps = '0;
				end
			end
		endfunction

		function void take_item(meter_item_t it);
			meter_reading_t want;
			logic [31:0]    wide;
			logic [63:0]    total;
			logic [63:0]    quot;
			logic [8:0]     misses_next;
			want = '0;
			if (it.mode == MODE_EVENT) begin
				capture_step(it.has_overflow, it.has_capture, it.capture_count);
			end else if (done) begin
				want.new_period = 1'b1;
				wr_idx = (wr_idx >= WINDOW_LEN - 1) ? 0 : wr_idx + 1;
				if (fill < WINDOW_LEN)
					fill++;
				if (wraps <= 1)
					wide = 32'(ticks);
				else
					wide = ((32'(wraps) - 32'd1) << 16) + 32'(ticks);
				want.period_ticks = wide[PERIOD_W-1:0];
				ring[wr_idx] = want.period_ticks;
				if (fill >= WINDOW_LEN) begin
					total = '0;
					foreach (ring[i]) total += 64'(ring[i]);
					if (total == '0) begin
						want.zero_sum_error = 1'b1;
						freq = '0;
					end else begin
						quot = (64'(numerator) << FRAC_W) / total;
						freq = (quot > 64'hFFFF_FFFF) ? '1 : quot[FREQ_W-1:0];
					end
				end
				done = 1'b0;
				armed = 1'b0;
				wraps = '0;
				misses = '0;
			end else begin
				misses_next = 9'(misses) + 9'd1;
				if (misses_next > 9'(loss_limit)) begin
					freq = '0;
					misses = '0;
					want.signal_lost = 1'b1;
				end else begin
					misses = misses_next[LOSS_W-1:0];
				end
			end
			want.freq_q16 = freq;
			readings_due.push_back(want);
		endfunction

		task report(string msg);
			$display("tb_top: mismatch: %s", msg);
			errors++;
		endtask

		task check_reading(meter_reading_t got);
			meter_reading_t want;
			if (readings_due.size() == 0) begin
				report($sformatf("result with nothing pending, freq %h", got.freq_q16));
				return;
			end
			want = readings_due.pop_front();
			if (got.freq_q16 !== want.freq_q16)
				report($sformatf("freq_q16 %h, want %h", got.freq_q16, want.freq_q16));
			if (got.period_ticks !== want.period_ticks)
				report($sformatf("period_ticks %h, want %h", got.period_ticks,
					want.period_ticks));
			if (got.new_period !== want.new_period)
				report($sformatf("new_period %b, want %b", got.new_period, want.new_period));
			if (got.zero_sum_error !== want.zero_sum_error)
				report($sformatf("zero_sum_error %b, want %b", got.zero_sum_error,
					want.zero_sum_error));
			if (got.signal_lost !== want.signal_lost)
				report($sformatf("signal_lost %b, want %b", got.signal_lost, want.signal_lost));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	icfm_in_if  item_ch ();
	icfm_out_if result_ch ();

	input_capture_frequency_meter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 20 ns period
	always #10 clk = ~clk;

	meter_tracker tracker;
	int           items_sent = 0;
	bit           no_idle = 1'b0;

	// idle length for either side: mostly none, sometimes short, rarely long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// wraps between the arming and closing edges of a measurement, long runs kept rare
	function automatic int pick_wraps();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 85)
			return 1;
		if (roll < 96)
			return $urandom_range(2, 4);
		if (roll < 98)
			return int'(OVF_LIMIT);
		return $urandom_range(5, 62);
	endfunction

	// one item transaction; entered and left just after a rising edge, so
	// valid is touched once per time step at most
	task automatic send_item(meter_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= it.mode;
		item_ch.has_overflow <= it.has_overflow;
		item_ch.has_capture <= it.has_capture;
		item_ch.capture_count <= it.capture_count;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		tracker.take_item(it);
		items_sent++;
	endtask

	task automatic timer_event(input logic wrap, input logic cap, input logic [CNT_W-1:0] cnt);
		meter_item_t it;
		it.mode = MODE_EVENT;
		it.has_overflow = wrap;
		it.has_capture = cap;
		it.capture_count = cnt;
		send_item(it);
	endtask

	// the other fields are don't-care on a poll, so they are scrambled
	task automatic poll();
		meter_item_t it;
		it.mode = MODE_POLL;
		it.has_overflow = 1'($urandom);
		it.has_capture = 1'($urandom);
		it.capture_count = 16'($urandom);
		send_item(it);
	endtask

	// arm edge, wraps with filler events, closing edge, then the poll that
	// takes the period; the last wrap sometimes rides on the closing edge
	task automatic measure(input logic [CNT_W-1:0] first, input int wraps,
			input logic [CNT_W-1:0] second);
		int merge;
		merge = (wraps > 0 && $urandom_range(0, 3) == 0) ? 1 : 0;
		timer_event(1'($urandom), 1'b1, first);
		for (int i = 0; i < wraps - merge; i++) begin
			if ($urandom_range(0, 5) == 0)
				timer_event(1'b0, 1'b0, 16'($urandom));
			if ($urandom_range(0, 15) == 0)
				poll();
			timer_event(1'b1, 1'b0, 16'($urandom));
		end
		timer_event(1'(merge), 1'b1, second);
		poll();
	endtask

	// 64th wrap ends the measurement with a zero period; an edge on that
	// same event starts a fresh one
	task automatic wrap_timeout();
		bit again;
		again = 1'($urandom);
		timer_event(1'b0, 1'b1, 16'($urandom));
		repeat (OVF_LIMIT) timer_event(1'b1, 1'b0, 16'($urandom));
		timer_event(1'b1, again, 16'($urandom));
		if (again)
			timer_event(1'b0, 1'b1, 16'($urandom));
		poll();
	endtask

	// tiny keeps periods short so a large numerator saturates the quotient
	task automatic random_sequence(input bit tiny);
		int               roll;
		logic [CNT_W-1:0] start;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			if (tiny) begin
				start = 16'($urandom_range(0, 32'hFFFF - 40));
				measure(start, 0, 16'(start + $urandom_range(1, 40)));
			end else begin
				measure(16'($urandom), pick_wraps(), 16'($urandom));
			end
		end else if (roll < 70) begin
			measure(CNT_MAX, 0, '0);
		end else if (roll < 72) begin
			wrap_timeout();
		end else if (roll < 87) begin
			repeat ($urandom_range(1, 4))
				timer_event(1'($urandom), 1'($urandom), 16'($urandom));
		end else begin
			repeat ($urandom_range(1, 25)) poll();
		end
	endtask

	task automatic random_phase(input int count, input bit tiny);
		int stop;
		stop = items_sent + count;
		while (items_sent < stop) random_sequence(tiny);
	endtask

	// hold the sender until every pending result is back, then let the
	// divider latency pass so the block is surely idle
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.readings_due.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// both registers, on back-to-back edges, while idle
	task automatic configure(input logic [NUM_W-1:0] num, input logic [LOSS_W-1:0] limit);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_CLOCK_NUMERATOR;
		cfg_wdata <= num;
		@(posedge clk);
		cfg_index <= REG_LOSS_LIMIT;
		cfg_wdata <= CFG_W'(limit);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_registers(num, limit);
	endtask

	// result side: random stalls, then take one result transaction
	initial begin : result_side
		int             stall;
		meter_reading_t got;
		result_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			got.freq_q16 = result_ch.freq_q16;
			got.period_ticks = result_ch.period_ticks;
			got.new_period = result_ch.new_period;
			got.zero_sum_error = result_ch.zero_sum_error;
			got.signal_lost = result_ch.signal_lost;
			tracker.check_reading(got);
		end
	end

	initial begin : stimulus
		tracker = new();
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.mode <= MODE_EVENT;
		item_ch.has_overflow <= 1'b0;
		item_ch.has_capture <= 1'b0;
		item_ch.capture_count <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_CLOCK_NUMERATOR;
		cfg_wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty poll at reset, wrap while idle
		poll();
		timer_event(1'b1, 1'b0, 16'h0000);
		// zero period from an edge at the top then one at zero, an event
		// while done is dropped, then the poll takes it
		timer_event(1'b0, 1'b1, CNT_MAX);
		timer_event(1'b0, 1'b1, 16'h0000);
		timer_event(1'b1, 1'b1, 16'h1234);
		poll();
		// full span without a wrap
		timer_event(1'b0, 1'b1, 16'h0000);
		timer_event(1'b0, 1'b1, CNT_MAX);
		poll();
		// equal counts take the wrap formula
		timer_event(1'b0, 1'b1, 16'h1234);
		timer_event(1'b0, 1'b1, 16'h1234);
		poll();
		// one wrap, second count below the first
		timer_event(1'b0, 1'b1, 16'd100);
		timer_event(1'b1, 1'b0, 16'h5555);
		timer_event(1'b0, 1'b1, 16'd50);
		poll();
		// wrap ignored on the arming event, then three wraps with the last
		// on the closing edge, so the extra wraps are added
		timer_event(1'b1, 1'b1, 16'h8000);
		timer_event(1'b1, 1'b0, 16'hAAAA);
		timer_event(1'b1, 1'b0, 16'h5555);
		timer_event(1'b1, 1'b1, 16'h7FFF);
		poll();
		timer_event(1'b0, 1'b0, 16'hAAAA);
		poll();

		// reset values of the registers
		random_phase(150, 1'b0);

		// large numerator with short periods: saturation, then a window of
		// zero periods, and loss on the first empty poll
		settle();
		configure(NUM_W'(100_000_000), 8'd0);
		random_phase(150, 1'b1);
		repeat (WINDOW_LEN) measure(CNT_MAX, 0, '0);
		random_phase(150, 1'b1);

		// smallest nonzero numerator, loss only after the longest run of empty polls
		settle();
		configure(NUM_W'(1), 8'd255);
		random_phase(150, 1'b0);
		repeat (257) poll();
		random_phase(150, 1'b0);

		// zero numerator
		settle();
		configure('0, 8'd1);
		random_phase(150, 1'b0);

		// random settings, both sides at full rate
		settle();
		configure(NUM_W'($urandom_range(1, 100_000_000)), LOSS_W'($urandom_range(0, 40)));
		no_idle = 1'b1;
		random_phase(350, 1'b0);
		no_idle = 1'b0;

		// back to the reset settings
		settle();
		configure(NUM_RESET, LOSS_RESET);
		random_phase(150, 1'b0);

		settle();
		if (tracker.errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	// hang guard, well beyond the slowest legal run
	initial begin : watchdog
		#40_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
